@@ hw/rtl/ttsp_pkg.sv @@
// Shared types, character codes and token helpers for the tagged token stream parser.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
package ttsp_pkg;

  // Result kinds carried in the result tuser field.
  localparam logic [2:0] KIND_INT  = 3'd0;
  localparam logic [2:0] KIND_HDR  = 3'd1;
  localparam logic [2:0] KIND_DATA = 3'd2;
  localparam logic [2:0] KIND_END  = 3'd3;
  localparam logic [2:0] KIND_ERR  = 3'd4;

  // Character codes used by the token grammar.
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_LOWZ  = 8'h7A;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_TAG  = 4'b0001,
    PH_NUM  = 4'b0010,
    PH_BODY = 4'b0100,
    PH_ERR  = 4'b1000
  } phase_t;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    phase_t      phase;
    logic [7:0]  tag;
    logic [31:0] mag;
    logic        neg;
    logic        seen;
    logic [30:0] rem;
  } st_t;

  // One result token.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tag;
    logic [31:0] value;
    logic [7:0]  data;
    logic        done;
  } tok_t;

  function automatic logic is_int_tag(input logic [7:0] b);
    is_int_tag = (b == CH_UNDER) || ((b >= CH_LOWA) && (b <= CH_LOWZ));
  endfunction

  function automatic logic is_span_tag(input logic [7:0] b);
    is_span_tag = (b >= CH_UPA) && (b <= CH_UPZ);
  endfunction

  function automatic tok_t mk_tok(input logic [2:0] kind, input logic [7:0] tag,
                                  input logic [31:0] value, input logic [7:0] data,
                                  input logic done);
    tok_t t;
    t.kind  = kind;
    t.tag   = tag;
    t.value = value;
    t.data  = data;
    t.done  = done;
    mk_tok  = t;
  endfunction

endpackage

@@ hw/rtl/ttsp_step.sv @@
// Next-state and result logic of the parser for one registered input byte.
// Depends on ttsp_pkg for the state, token types and character codes.
module ttsp_step (
  input  ttsp_pkg::st_t  st,
  input  logic [7:0]     data_byte,
  input  logic           final_byte,
  output ttsp_pkg::st_t  st_nxt,
  output logic           push0,
  output logic           push1,
  output ttsp_pkg::tok_t res0,
  output ttsp_pkg::tok_t res1
);

  logic              is_digit;
  logic [35:0]       acc;
  logic [35:0]       limit;
  logic [31:0]       sval;
  logic [30:0]       len_m1;
  logic [30:0]       rem_m1;
  logic              tk_err;
  ttsp_pkg::phase_t  tk_phase;
  ttsp_pkg::phase_t  fail_phase;
  ttsp_pkg::tok_t    tk_res;
  ttsp_pkg::tok_t    err_res;
  ttsp_pkg::tok_t    end_res;

  // Digit accumulate: magnitude times ten plus the new digit, with range limit.
  assign is_digit = (data_byte >= ttsp_pkg::CH_ZERO) && (data_byte <= ttsp_pkg::CH_NINE);
  assign acc      = ({4'b0, st.mag} << 3) + ({4'b0, st.mag} << 1) + {32'b0, data_byte[3:0]};
  assign limit    = st.neg ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;
  assign sval     = st.neg ? (32'd0 - st.mag) : st.mag;
  assign len_m1   = st.mag[30:0] - 31'd1;
  assign rem_m1   = st.rem - 31'd1;

  // A new tag byte: bad tags and a tag on the final byte are errors.
  assign tk_err   = !(ttsp_pkg::is_int_tag(data_byte) || ttsp_pkg::is_span_tag(data_byte))
                    || final_byte;
  assign tk_phase = tk_err ? (final_byte ? ttsp_pkg::PH_TAG : ttsp_pkg::PH_ERR)
                           : ttsp_pkg::PH_NUM;
  assign tk_res   = ttsp_pkg::mk_tok(ttsp_pkg::KIND_ERR, data_byte, 32'd0, 8'd0, 1'b0);

  // Errors inside a token carry the held tag; the final byte ends the sticky error.
  assign fail_phase = final_byte ? ttsp_pkg::PH_TAG : ttsp_pkg::PH_ERR;
  assign err_res    = ttsp_pkg::mk_tok(ttsp_pkg::KIND_ERR, st.tag, 32'd0, 8'd0, 1'b0);
  assign end_res    = ttsp_pkg::mk_tok(ttsp_pkg::KIND_END, 8'd0, 32'd0, 8'd0, 1'b0);

  always_comb begin
    st_nxt = st;
    push0  = 1'b0;
    push1  = 1'b0;
    res0   = '0;
    res1   = '0;
    unique case (st.phase)
      ttsp_pkg::PH_TAG: begin
        st_nxt.tag   = data_byte;
        st_nxt.mag   = 32'd0;
        st_nxt.neg   = 1'b0;
        st_nxt.seen  = 1'b0;
        st_nxt.phase = tk_phase;
        push0        = tk_err;
        res0         = tk_res;
      end
      ttsp_pkg::PH_NUM: begin
        if (is_digit) begin
          if (acc > limit) begin
            push0        = 1'b1;
            res0         = err_res;
            st_nxt.phase = fail_phase;
          end else begin
            st_nxt.mag  = acc[31:0];
            st_nxt.seen = 1'b1;
            if (final_byte) begin
              push0        = 1'b1;
              st_nxt.phase = ttsp_pkg::PH_TAG;
              if (ttsp_pkg::is_int_tag(st.tag)) begin
                res0  = ttsp_pkg::mk_tok(ttsp_pkg::KIND_INT, st.tag,
                                         st.neg ? (32'd0 - acc[31:0]) : acc[31:0],
                                         8'd0, 1'b0);
                push1 = 1'b1;
                res1  = end_res;
              end else begin
                res0 = err_res;
              end
            end
          end
        end else if ((data_byte == ttsp_pkg::CH_MINUS) && !st.seen && !st.neg) begin
          st_nxt.neg = 1'b1;
          if (final_byte) begin
            push0        = 1'b1;
            res0         = err_res;
            st_nxt.phase = ttsp_pkg::PH_TAG;
          end
        end else if (!st.seen) begin
          push0        = 1'b1;
          res0         = err_res;
          st_nxt.phase = fail_phase;
        end else if (ttsp_pkg::is_int_tag(st.tag)) begin
          // The byte that ends the number is the next tag.
          push0        = 1'b1;
          res0         = ttsp_pkg::mk_tok(ttsp_pkg::KIND_INT, st.tag, sval, 8'd0, 1'b0);
          st_nxt.tag   = data_byte;
          st_nxt.mag   = 32'd0;
          st_nxt.neg   = 1'b0;
          st_nxt.seen  = 1'b0;
          st_nxt.phase = tk_phase;
          push1        = tk_err;
          res1         = tk_res;
        end else if (st.neg || (st.mag == 32'd0) || (data_byte != ttsp_pkg::CH_BANG)) begin
          push0        = 1'b1;
          res0         = err_res;
          st_nxt.phase = fail_phase;
        end else if (final_byte && (len_m1 != 31'd0)) begin
          // Span cut short by the final byte.
          push0        = 1'b1;
          res0         = err_res;
          st_nxt.phase = ttsp_pkg::PH_TAG;
        end else begin
          st_nxt.rem   = len_m1;
          push0        = 1'b1;
          res0         = ttsp_pkg::mk_tok(ttsp_pkg::KIND_HDR, st.tag, {1'b0, len_m1}, 8'd0,
                                          len_m1 == 31'd0);
          st_nxt.phase = (len_m1 == 31'd0) ? ttsp_pkg::PH_TAG : ttsp_pkg::PH_BODY;
          push1        = final_byte;
          res1         = end_res;
        end
      end
      ttsp_pkg::PH_BODY: begin
        if (st.rem == 31'd0) begin
          st_nxt.tag   = data_byte;
          st_nxt.mag   = 32'd0;
          st_nxt.neg   = 1'b0;
          st_nxt.seen  = 1'b0;
          st_nxt.phase = tk_phase;
          push0        = tk_err;
          res0         = tk_res;
        end else begin
          st_nxt.rem = rem_m1;
          push0      = 1'b1;
          if (final_byte && (rem_m1 != 31'd0)) begin
            res0         = err_res;
            st_nxt.phase = ttsp_pkg::PH_TAG;
          end else begin
            res0  = ttsp_pkg::mk_tok(ttsp_pkg::KIND_DATA, st.tag, 32'd0, data_byte,
                                     rem_m1 == 31'd0);
            push1 = final_byte;
            res1  = end_res;
            if (rem_m1 == 31'd0) begin
              st_nxt.phase = ttsp_pkg::PH_TAG;
            end
          end
        end
      end
      default: begin
        // Sticky error: ignore bytes until the final one.
        if (final_byte) begin
          st_nxt.phase = ttsp_pkg::PH_TAG;
        end
      end
    endcase
  end

endmodule

@@ hw/rtl/ttsp_rq.sv @@
// Result queue of the parser: takes up to two tokens a cycle, delivers one a cycle while pop is high.
// Depends on ttsp_pkg for the token type.
module ttsp_rq #(
  parameter int DEPTH = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push0,
  input  logic           push1,
  input  ttsp_pkg::tok_t res0,
  input  ttsp_pkg::tok_t res1,
  input  logic           pop,
  output ttsp_pkg::tok_t head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  ttsp_pkg::tok_t  mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   wr_ptr_nxt;
  logic [AW-1:0]   wr_ptr1;
  logic [AW-1:0]   rd_ptr_r;
  logic [AW-1:0]   rd_ptr_nxt;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;
  logic            do_pop;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    inc = (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  assign do_pop  = pop && (cnt_r != '0);
  assign wr_ptr1 = inc(wr_ptr_r);

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push0 && push1) begin
      wr_ptr_nxt = inc(wr_ptr1);
    end else if (push0) begin
      wr_ptr_nxt = wr_ptr1;
    end
    rd_ptr_nxt = do_pop ? inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push0) + CW'(push0 && push1) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Token storage; the second token of a byte goes to the following entry.
  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wr_ptr_r] <= res0;
    end
    if (push0 && push1) begin
      mem_r[wr_ptr1] <= res1;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign count = cnt_r;

endmodule

@@ hw/rtl/tagged_token_stream_parser.sv @@
// Tagged token stream parser: one byte per cycle in and one token per cycle out when
// neither side stalls. The first token of a byte passes through the input stage register
// and the result queue before it appears on out_*.
// Throughput: one byte per cycle while the result queue drains; a byte gives at most
// two tokens; input stalls unless the queue can hold those of any staged byte and the next.
// Reset (rst_n low, synchronous) empties the queue and returns the parser to tag phase.
// Depends on ttsp_pkg, ttsp_step and ttsp_rq.
module tagged_token_stream_parser #(
  parameter int RQ_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] token_tag, [39:8] token_value, [47:40] span_data
  output logic [2:0]  out_tuser,  // [2:0] token_kind
  output logic        out_tlast   // span_done
);

  localparam int CW = $clog2(RQ_DEPTH + 1);
  localparam logic [CW:0] ROOM_LIMIT = (CW + 1)'(RQ_DEPTH - 2);

  logic            acc_in;
  logic            s_v_r;
  logic [7:0]      s_byte_r;
  logic            s_last_r;
  ttsp_pkg::st_t   st_r;
  ttsp_pkg::st_t   st_nxt;
  logic            push0;
  logic            push1;
  ttsp_pkg::tok_t  res0;
  ttsp_pkg::tok_t  res1;
  ttsp_pkg::tok_t  head;
  logic [CW-1:0]   count;
  logic [CW:0]     reserved;

  // Accept a request only if the queue can take the tokens of the staged byte and this one.
  assign reserved  = {1'b0, count} + (s_v_r ? (CW + 1)'(2) : '0);
  assign in_tready = (reserved <= ROOM_LIMIT);
  assign acc_in    = in_tvalid && in_tready;

  // Input stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else begin
      s_v_r <= acc_in;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      s_byte_r <= in_tdata;
      s_last_r <= in_tlast;
    end
  end

  // Parser state, advanced once per staged byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= ttsp_pkg::PH_TAG;
      st_r.tag   <= '0;
      st_r.mag   <= '0;
      st_r.neg   <= 1'b0;
      st_r.seen  <= 1'b0;
      st_r.rem   <= '0;
    end else if (s_v_r) begin
      st_r <= st_nxt;
    end
  end

  ttsp_step u_step (
    .st         (st_r),
    .data_byte  (s_byte_r),
    .final_byte (s_last_r),
    .st_nxt     (st_nxt),
    .push0      (push0),
    .push1      (push1),
    .res0       (res0),
    .res1       (res1)
  );

  ttsp_rq #(
    .DEPTH (RQ_DEPTH)
  ) u_rq (
    .clk   (clk),
    .rst_n (rst_n),
    .push0 (s_v_r && push0),
    .push1 (s_v_r && push1),
    .res0  (res0),
    .res1  (res1),
    .pop   (out_tready),
    .head  (head),
    .count (count)
  );

  // Result channel driven from the queue head.
  assign out_tvalid = (count != '0);
  assign out_tdata  = {head.data, head.value, head.tag};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.done;

endmodule
